// ===== hdl/psg_envelope_generator_macros.svh =====
// Assertion helpers shared by the envelope checker.
`ifndef PSG_ENVELOPE_GENERATOR_MACROS_SVH
`define PSG_ENVELOPE_GENERATOR_MACROS_SVH

// Property sampled on the rising clock edge, ignored while reset is held.
`define PSG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property sampled on the rising clock edge, also checked through reset.
`define PSG_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== hdl/psg_env_pkg.sv =====
`default_nettype none

package psg_env_pkg;

    typedef logic [4:0]  t_level;
    typedef logic [1:0]  t_phase;
    typedef logic [15:0] t_period;
    typedef logic [2:0]  t_cfg_idx;

    // Envelope phases
    localparam t_phase PH_NORMAL   = 2'd0;
    localparam t_phase PH_INVERTED = 2'd1;
    localparam t_phase PH_HOLDING  = 2'd2;

    localparam t_level LEVEL_MIN = 5'd0;
    localparam t_level LEVEL_MAX = 5'd31;

    // Configuration register indexes
    localparam t_cfg_idx CFG_ENV_PERIOD      = 3'd0;
    localparam t_cfg_idx CFG_SHAPE_CONTINUE  = 3'd1;
    localparam t_cfg_idx CFG_SHAPE_ATTACK    = 3'd2;
    localparam t_cfg_idx CFG_SHAPE_ALTERNATE = 3'd3;
    localparam t_cfg_idx CFG_SHAPE_HOLD      = 3'd4;

    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [3:0] clocks;
    } t_env_in;

    typedef struct packed {
        t_level level;
        t_phase phase;
        logic   stepped;
    } t_env_out;

endpackage

`default_nettype wire

// ===== hdl/psg_stream_if.sv =====
`default_nettype none

interface psg_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/psg_envelope_generator.sv =====
// Channel    | Dir | Payload                         | Handshake
// -----------+-----+---------------------------------+-------------
// i_env_in   | in  | clocks (4 b)                    | valid/ready
// o_env_out  | out | level (5 b), phase (2 b),       | valid/ready
//            |     | stepped (1 b)                   |
// i_cfg_*    | in  | idx (3 b), data (16 b)          | write enable
//
// One beat per cycle while o_env_out.ready stays high: the input register takes a
// beat, then prescaler, period counter and envelope step resolve in one pass into
// the output register once free or drained. Synchronous active-low reset clears the
// counters, level (0), phase (normal), shape bits and period. While a result
// waits, the input register takes one more beat; then i_env_in.ready drops.
`default_nettype none

module psg_envelope_generator #(
    parameter int PRESCALE = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    psg_stream_if.sink                                i_env_in,
    psg_stream_if.source                              o_env_out,
    input  wire logic                                 i_cfg_we,
    input  wire psg_env_pkg::t_cfg_idx                i_cfg_idx,
    input  wire logic [psg_env_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import psg_env_pkg::*;

    // Prescaler count stays below PRESCALE; the sum of count and clocks
    // stays below twice PRESCALE: at least one bit more, and never under 4 bits.
    localparam int PW = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;
    localparam int CW = (PW + 1 > 4) ? PW + 1 : 4;
    localparam logic [CW-1:0] PRESCALE_C = CW'(PRESCALE);

    // Configuration
    t_period r_env_period;
    logic    r_continue;
    logic    r_attack;
    logic    r_alternate;
    logic    r_hold;

    // Envelope state
    logic [PW-1:0] r_presc;
    logic [PW-1:0] n_presc;
    t_period       r_period_cnt;
    t_period       n_period_cnt;
    t_level        r_level;
    t_level        n_level;
    t_phase        r_phase;
    t_phase        n_phase;

    // Pipeline
    logic       r_in_valid;
    logic [3:0] r_clocks;
    logic       r_out_valid;
    t_env_out   r_out;

    logic          advance;
    logic          fire;
    logic [CW-1:0] clk_ext;
    logic [CW-1:0] clk_sat;
    logic [CW-1:0] presc_sum;
    logic          tick;
    logic          step;
    logic          up;
    logic          at_end;
    t_level        ramp_level;

    // Move the input register on whenever the output register is free or drained.
    assign advance         = !r_out_valid || o_env_out.ready;
    assign fire            = r_in_valid && advance;
    assign i_env_in.ready  = !r_in_valid || advance;
    assign o_env_out.valid = r_out_valid;
    assign o_env_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env_period <= '0;
            r_continue   <= 1'b0;
            r_attack     <= 1'b0;
            r_alternate  <= 1'b0;
            r_hold       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENV_PERIOD:      r_env_period <= i_cfg_data;
                CFG_SHAPE_CONTINUE:  r_continue   <= i_cfg_data[0];
                CFG_SHAPE_ATTACK:    r_attack     <= i_cfg_data[0];
                CFG_SHAPE_ALTERNATE: r_alternate  <= i_cfg_data[0];
                CFG_SHAPE_HOLD:      r_hold       <= i_cfg_data[0];
                default: begin
                    // Drop writes to unmapped indexes.
                end
            endcase
        end
    end

    // Input register: hold the beat until the step stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_env_in.valid && i_env_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_env_in.valid && i_env_in.ready) begin
            r_clocks <= i_env_in.data.clocks;
        end
    end

    // Prescaler: saturate the clock count at PRESCALE, so at most one tick.
    always_comb begin
        clk_ext   = CW'(r_clocks);
        clk_sat   = (clk_ext > PRESCALE_C) ? PRESCALE_C : clk_ext;
        presc_sum = CW'(r_presc) + clk_sat;
        tick      = presc_sum >= PRESCALE_C;
        n_presc   = tick ? PW'(presc_sum - PRESCALE_C) : PW'(presc_sum);
    end

    // Period counter: count down on each tick, reload and step at zero.
    always_comb begin
        step         = 1'b0;
        n_period_cnt = r_period_cnt;
        if (tick) begin
            if (r_period_cnt != '0) begin
                n_period_cnt = r_period_cnt - 16'd1;
            end else begin
                n_period_cnt = r_env_period;
                step         = 1'b1;
            end
        end
    end

    // Envelope step. Normal phase ramps per attack, inverted ramps against it;
    // at the end of a ramp the shape bits pick the landing level and phase.
    always_comb begin
        up         = (r_phase == PH_NORMAL) ? r_attack : !r_attack;
        at_end     = up ? (r_level == LEVEL_MAX) : (r_level == LEVEL_MIN);
        ramp_level = up ? r_level + 5'd1 : r_level - 5'd1;
        n_level    = r_level;
        n_phase    = r_phase;
        if (step) begin
            unique case (r_phase)
                PH_NORMAL: begin
                    if (!at_end) begin
                        n_level = ramp_level;
                    end else begin
                        n_level = (r_continue && (!r_attack ^ r_alternate ^ r_hold))
                                  ? LEVEL_MAX : LEVEL_MIN;
                        if (r_hold || !r_continue) begin
                            n_phase = PH_HOLDING;
                        end else if (r_alternate) begin
                            n_phase = PH_INVERTED;
                        end
                    end
                end
                PH_INVERTED: begin
                    if (!at_end) begin
                        n_level = ramp_level;
                    end else begin
                        n_level = r_attack ? LEVEL_MIN : LEVEL_MAX;
                        n_phase = PH_NORMAL;
                    end
                end
                PH_HOLDING: begin
                    n_level = (r_continue && (r_attack ^ r_alternate))
                              ? LEVEL_MAX : LEVEL_MIN;
                end
                default: begin
                    // Unused phase code: leave level and phase alone.
                end
            endcase
        end
    end

    // Advance the envelope state only when a beat passes the step stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc      <= '0;
            r_period_cnt <= '0;
            r_level      <= LEVEL_MIN;
            r_phase      <= PH_NORMAL;
        end else if (fire) begin
            r_presc      <= n_presc;
            r_period_cnt <= n_period_cnt;
            r_level      <= n_level;
            r_phase      <= n_phase;
        end
    end

    // Output register: load on fire, drop valid once the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_env_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.level   <= n_level;
            r_out.phase   <= n_phase;
            r_out.stepped <= step;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/psg_env_checker.sv =====
`default_nettype none

`include "psg_envelope_generator_macros.svh"

module psg_env_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire psg_env_pkg::t_level i_out_level,
    input wire psg_env_pkg::t_phase i_out_phase,
    input wire logic                i_out_stepped
);
    import psg_env_pkg::*;

    logic   out_beat;
    t_level r_last_level;
    t_phase r_last_phase;

    assign out_beat = i_out_valid && i_out_ready;

    // Track the last delivered level and phase, starting at the reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= LEVEL_MIN;
            r_last_phase <= PH_NORMAL;
        end else if (out_beat) begin
            r_last_level <= i_out_level;
            r_last_phase <= i_out_phase;
        end
    end

    `PSG_ASSERT_RST(a_reset_clears_valid, !i_rst_n |=> !i_out_valid, "output valid after reset")
    `PSG_ASSERT(a_stall_holds, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_level) && $stable(i_out_phase) && $stable(i_out_stepped), "stalled result beat changed")
    `PSG_ASSERT(a_no_step_no_change, out_beat && !i_out_stepped |-> i_out_level == r_last_level && i_out_phase == r_last_phase, "level or phase moved without a step")
    `PSG_ASSERT(a_holding_sticks, out_beat && r_last_phase == PH_HOLDING |-> i_out_phase == PH_HOLDING, "left the holding phase")

endmodule

bind psg_envelope_generator psg_env_checker u_psg_env_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_env_out.valid),
    .i_out_ready  (o_env_out.ready),
    .i_out_level  (o_env_out.data.level),
    .i_out_phase  (o_env_out.data.phase),
    .i_out_stepped(o_env_out.data.stepped)
);

`default_nettype wire
